>>> rtl/lsms_pkg.sv
// Shared types, constants and helpers for the LCD scanline mode sequencer.
// No dependencies; the RTL files refer to this package by scoped names, the bench imports it.
package lsms_pkg;

  localparam int VISIBLE_LINES = 144;
  localparam int LAST_LINE     = 153;
  localparam int MAX_RESULTS   = 4;
  localparam int FIFO_DEPTH    = 2;

  localparam int ACC_W     = 16;
  localparam int LINE_W    = 8;
  localparam int CFG_W     = 10;
  localparam int CYC_W     = 8;
  localparam int RES_IDX_W = $clog2(MAX_RESULTS);
  localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CFG_SCAN      = 2'd0,
    CFG_TRANSFER  = 2'd1,
    CFG_HBLANK    = 2'd2,
    CFG_WRAP_WAIT = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    EV_TRANSFER    = 3'd0,
    EV_HBLANK      = 3'd1,
    EV_NEW_LINE    = 3'd2,
    EV_VBLANK_STEP = 3'd3,
    EV_WRAP        = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_SCAN     = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_TRANSFER = 2'd1,
    PH_HBLANK   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] scan;
    logic [CFG_W-1:0] transfer;
    logic [CFG_W-1:0] hblank;
    logic [CFG_W-1:0] wrap_wait;
  } cfg_regs_t;

  typedef struct packed {
    logic [CYC_W-1:0]  cycles;
    logic              display_on;
    logic              stopped;
    logic [3:0]        stat_int_enables;
    logic              ie_stat;
    logic              ie_vblank;
    logic [LINE_W-1:0] compare_line;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [LINE_W-1:0] line;
    logic [1:0]        mode;
    logic              coincidence;
    logic              stat_irq;
    logic              vblank_irq;
    logic              frame_done;
    logic              last;
  } out_item_t;

  typedef struct packed {
    event_t            ev;
    logic [LINE_W-1:0] line;
    mode_t             mode;
    logic              coincidence;
    logic              stat_irq;
    logic              vblank_irq;
    logic              frame_done;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [RES_IDX_W-1:0]      last_idx;
  } bundle_t;

  function automatic result_t mk_result(event_t ev, logic [LINE_W-1:0] line, mode_t mode,
                                        logic cf, logic sirq, logic virq, logic fd);
    result_t r;
    r.ev          = ev;
    r.line        = line;
    r.mode        = mode;
    r.coincidence = cf;
    r.stat_irq    = sirq;
    r.vblank_irq  = virq;
    r.frame_done  = fd;
    return r;
  endfunction

endpackage

>>> rtl/lsms_if.sv
// Valid/ready channel interfaces for sequencer input items and result items.
// Depends on lsms_pkg for the payload types.
interface lsms_in_if;
  logic               valid;
  logic               ready;
  lsms_pkg::in_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

interface lsms_out_if;
  logic                valid;
  logic                ready;
  lsms_pkg::out_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

>>> rtl/lsms_seq.sv
// Input register, sequencer state and single-pass step logic.
// Produces one bundle of up to four results per item that yields any result. Depends on lsms_pkg, lsms_if.
module lsms_seq (
  input  logic                clk,
  input  logic                rst,
  lsms_in_if.sink             items,
  input  lsms_pkg::cfg_regs_t cfg,
  input  logic                fifo_ready,
  output logic                push,
  output lsms_pkg::bundle_t   bundle
);

  logic                            ir_valid;
  lsms_pkg::in_item_t              ir;
  logic                            consume;

  logic [lsms_pkg::ACC_W-1:0]      acc;
  logic [lsms_pkg::LINE_W-1:0]     line;
  lsms_pkg::phase_t                phase;
  lsms_pkg::mode_t                 mode;
  logic                            cflag;

  logic [lsms_pkg::ACC_W-1:0]      acc_next;
  logic [lsms_pkg::LINE_W-1:0]     line_next;
  lsms_pkg::phase_t                phase_next;
  lsms_pkg::mode_t                 mode_next;
  logic                            cflag_next;
  logic [lsms_pkg::CNT_W-1:0]      n;
  logic                            ign;

  always_comb begin
    logic [lsms_pkg::ACC_W:0]        sum;
    logic [lsms_pkg::ACC_W-1:0]      a;
    logic [lsms_pkg::LINE_W-1:0]     ln;
    lsms_pkg::phase_t                ph;
    lsms_pkg::mode_t                 md;
    logic                            cf;
    logic [lsms_pkg::CNT_W-1:0]      k;
    logic                            sirq;
    logic                            virq;
    logic                            fd;
    lsms_pkg::bundle_t               b;
    sum  = {1'b0, acc} + (lsms_pkg::ACC_W + 1)'(ir.cycles);
    a    = sum[lsms_pkg::ACC_W] ? '1 : sum[lsms_pkg::ACC_W-1:0];
    ln   = line;
    ph   = phase;
    md   = mode;
    cf   = cflag;
    k    = '0;
    b    = '0;
    sirq = 1'b0;
    virq = 1'b0;
    fd   = 1'b0;
    ign  = !ir.display_on || ir.stopped;
    if (!ign) begin
      if (ln < lsms_pkg::LINE_W'(lsms_pkg::VISIBLE_LINES)) begin
        if (k < lsms_pkg::CNT_W'(lsms_pkg::MAX_RESULTS) && ph == lsms_pkg::PH_SCAN &&
            a >= lsms_pkg::ACC_W'(cfg.scan)) begin
          ph = lsms_pkg::PH_TRANSFER;
          a  = a - lsms_pkg::ACC_W'(cfg.scan);
          md = lsms_pkg::MODE_TRANSFER;
          b.res[k[lsms_pkg::RES_IDX_W-1:0]] =
            lsms_pkg::mk_result(lsms_pkg::EV_TRANSFER, ln, md, cf, 1'b0, 1'b0, 1'b0);
          k = k + 1'b1;
        end
        if (k < lsms_pkg::CNT_W'(lsms_pkg::MAX_RESULTS) && ph == lsms_pkg::PH_TRANSFER &&
            a >= lsms_pkg::ACC_W'(cfg.transfer)) begin
          ph = lsms_pkg::PH_HBLANK;
          a  = a - lsms_pkg::ACC_W'(cfg.transfer);
          md = lsms_pkg::MODE_HBLANK;
          b.res[k[lsms_pkg::RES_IDX_W-1:0]] =
            lsms_pkg::mk_result(lsms_pkg::EV_HBLANK, ln, md, cf,
                                ir.ie_stat && ir.stat_int_enables[0], 1'b0, 1'b0);
          k = k + 1'b1;
        end
        if (k < lsms_pkg::CNT_W'(lsms_pkg::MAX_RESULTS) && ph == lsms_pkg::PH_HBLANK &&
            a >= lsms_pkg::ACC_W'(cfg.hblank)) begin
          ln = ln + lsms_pkg::LINE_W'(1);
          ph = lsms_pkg::PH_SCAN;
          a  = a - lsms_pkg::ACC_W'(cfg.hblank);
          if (ln == lsms_pkg::LINE_W'(lsms_pkg::VISIBLE_LINES)) begin
            md   = lsms_pkg::MODE_VBLANK;
            sirq = ir.ie_stat && ir.stat_int_enables[1];
            virq = ir.ie_vblank;
            fd   = 1'b1;
          end else begin
            md   = lsms_pkg::MODE_SCAN;
            sirq = ir.ie_stat && ir.stat_int_enables[2];
          end
          b.res[k[lsms_pkg::RES_IDX_W-1:0]] =
            lsms_pkg::mk_result(lsms_pkg::EV_NEW_LINE, ln, md, cf, sirq, virq, fd);
          k = k + 1'b1;
        end
      end
      if (k < lsms_pkg::CNT_W'(lsms_pkg::MAX_RESULTS) &&
          ln >= lsms_pkg::LINE_W'(lsms_pkg::VISIBLE_LINES) &&
          ln < lsms_pkg::LINE_W'(lsms_pkg::LAST_LINE) &&
          a >= lsms_pkg::ACC_W'(cfg.hblank)) begin
        ln = ln + lsms_pkg::LINE_W'(1);
        a  = a - lsms_pkg::ACC_W'(cfg.hblank);
        cf = (ir.compare_line == ln);
        b.res[k[lsms_pkg::RES_IDX_W-1:0]] =
          lsms_pkg::mk_result(lsms_pkg::EV_VBLANK_STEP, ln, md, cf,
                              cf && ir.ie_stat && ir.stat_int_enables[3], 1'b0, 1'b0);
        k = k + 1'b1;
      end
      if (k < lsms_pkg::CNT_W'(lsms_pkg::MAX_RESULTS) &&
          ln == lsms_pkg::LINE_W'(lsms_pkg::LAST_LINE) &&
          a >= lsms_pkg::ACC_W'(cfg.wrap_wait)) begin
        ln = '0;
        ph = lsms_pkg::PH_SCAN;
        a  = a - lsms_pkg::ACC_W'(cfg.wrap_wait);
        md = lsms_pkg::MODE_SCAN;
        b.res[k[lsms_pkg::RES_IDX_W-1:0]] =
          lsms_pkg::mk_result(lsms_pkg::EV_WRAP, ln, md, cf,
                              ir.ie_stat && ir.stat_int_enables[2], 1'b0, 1'b0);
        k = k + 1'b1;
      end
    end
    b.last_idx = lsms_pkg::RES_IDX_W'(k - 1'b1);
    if (ign) begin
      acc_next = acc;
    end else begin
      acc_next = a;
    end
    line_next  = ln;
    phase_next = ph;
    mode_next  = md;
    cflag_next = cf;
    n          = k;
    bundle     = b;
  end

  assign consume     = ir_valid && (fifo_ready || n == '0);
  assign push        = consume && n != '0;
  assign items.ready = !rst && (!ir_valid || consume);

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (items.ready) begin
      ir_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      ir <= items.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      line  <= '0;
      phase <= lsms_pkg::PH_SCAN;
      mode  <= lsms_pkg::MODE_HBLANK;
      cflag <= 1'b0;
    end else if (consume) begin
      acc   <= acc_next;
      line  <= line_next;
      phase <= phase_next;
      mode  <= mode_next;
      cflag <= cflag_next;
    end
  end

  a_ignored_holds: assert property (@(posedge clk) disable iff (rst)
    (consume && ign) |=> ($stable(acc) && $stable(line) && $stable(phase)))
    else $error("ignored item changed sequencer state");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    line <= lsms_pkg::LINE_W'(lsms_pkg::LAST_LINE))
    else $error("line beyond last line");

  a_no_push_ignored: assert property (@(posedge clk) disable iff (rst)
    (ir_valid && ign) |-> !push)
    else $error("ignored item produced results");

endmodule

>>> rtl/lsms_out.sv
// Two-entry bundle queue and result serializer: one result transfer per cycle while the receiver is ready.
// Depends on lsms_pkg and lsms_if.
module lsms_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lsms_pkg::bundle_t bundle,
  output logic              fifo_ready,
  lsms_out_if.source        results
);

  lsms_pkg::bundle_t               q [lsms_pkg::FIFO_DEPTH];
  logic [lsms_pkg::PTR_W-1:0]      wr_ptr;
  logic [lsms_pkg::PTR_W-1:0]      rd_ptr;
  logic [lsms_pkg::FCNT_W-1:0]     cnt;
  logic [lsms_pkg::RES_IDX_W-1:0]  idx;
  lsms_pkg::bundle_t               head;
  lsms_pkg::result_t               r;
  logic                            is_last;
  logic                            xfer;
  logic                            pop;

  assign head       = q[rd_ptr];
  assign r          = head.res[idx];
  assign is_last    = (idx == head.last_idx);
  assign xfer       = results.valid && results.ready;
  assign pop        = xfer && is_last;
  assign fifo_ready = (cnt != lsms_pkg::FCNT_W'(lsms_pkg::FIFO_DEPTH));

  assign results.valid = (cnt != '0);
  always_comb begin
    results.item.event_res   = r.ev;
    results.item.line        = r.line;
    results.item.mode        = r.mode;
    results.item.coincidence = r.coincidence;
    results.item.stat_irq    = r.stat_irq;
    results.item.vblank_irq  = r.vblank_irq;
    results.item.frame_done  = r.frame_done;
    results.item.last        = is_last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
      idx    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lsms_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lsms_pkg::PTR_W'(1);
        idx    <= '0;
      end else if (xfer) begin
        idx <= idx + lsms_pkg::RES_IDX_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + lsms_pkg::FCNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - lsms_pkg::FCNT_W'(1);
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> fifo_ready)
    else $error("bundle pushed into full queue");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (idx <= head.last_idx))
    else $error("result index past end of bundle");

endmodule

>>> rtl/lcd_scanline_mode_sequencer_core.sv
// An accepted item is held in the input register; its bundle is written into the result queue
// when the queue has room, and results are offered from the queue head.
// Throughput: one item per cycle while the result queue has room; each result takes one
// output transfer, so an item with k results (up to four) takes k output transfers.
// The two-entry result queue between step logic and output sets the stall point.
// Reset (rst, synchronous) restores register defaults and clears state; no clearing pass.
module lcd_scanline_mode_sequencer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [lsms_pkg::CFG_W-1:0] cfg_data,
  lsms_in_if.sink                    items,
  lsms_out_if.source                 results
);

  lsms_pkg::cfg_regs_t cfg;
  lsms_pkg::bundle_t   bundle;
  logic                push;
  logic                fifo_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan      <= lsms_pkg::CFG_W'(80);
      cfg.transfer  <= lsms_pkg::CFG_W'(172);
      cfg.hblank    <= lsms_pkg::CFG_W'(204);
      cfg.wrap_wait <= lsms_pkg::CFG_W'(456);
    end else if (cfg_we) begin
      unique case (lsms_pkg::cfg_index_t'(cfg_index))
        lsms_pkg::CFG_SCAN:      cfg.scan      <= cfg_data;
        lsms_pkg::CFG_TRANSFER:  cfg.transfer  <= cfg_data;
        lsms_pkg::CFG_HBLANK:    cfg.hblank    <= cfg_data;
        lsms_pkg::CFG_WRAP_WAIT: cfg.wrap_wait <= cfg_data;
        default: ;
      endcase
    end
  end

  lsms_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .cfg        (cfg),
    .fifo_ready (fifo_ready),
    .push       (push),
    .bundle     (bundle)
  );

  lsms_out u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .bundle     (bundle),
    .fifo_ready (fifo_ready),
    .results    (results)
  );

endmodule

>>> tb/tb_lcd_scanline_mode_sequencer_core.sv
// Self-checking bench for lcd_scanline_mode_sequencer_core: directed and random item
// streams with random idling, results checked against an in-bench scanline tracker.
// Depends on lsms_pkg, lsms_in_if/lsms_out_if and the core RTL.
module tb_lcd_scanline_mode_sequencer_core;
  import lsms_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  class scanline_tracker;
    int        thr_scan, thr_xfer, thr_hblank, thr_wrap;
    int        acc;
    int        line;
    int        pub_line;
    phase_t    phase;
    mode_t     mode;
    logic      cf;
    out_item_t due_results[$];

    function new();
      thr_scan   = 80;
      thr_xfer   = 172;
      thr_hblank = 204;
      thr_wrap   = 456;
      acc        = 0;
      line       = 0;
      pub_line   = 0;
      phase      = PH_SCAN;
      mode       = MODE_HBLANK;
      cf         = 1'b0;
    endfunction

    function void set_reg(cfg_index_t idx, int v);
      case (idx)
        CFG_SCAN:      thr_scan   = v & 'h3ff;
        CFG_TRANSFER:  thr_xfer   = v & 'h3ff;
        CFG_HBLANK:    thr_hblank = v & 'h3ff;
        CFG_WRAP_WAIT: thr_wrap   = v & 'h3ff;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void queue_result(event_t ev, logic sirq, logic virq, logic fd);
      out_item_t r;
      r.event_res   = ev;
      r.line        = line[7:0];
      r.mode        = mode;
      r.coincidence = cf;
      r.stat_irq    = sirq;
      r.vblank_irq  = virq;
      r.frame_done  = fd;
      r.last        = 1'b0;
      due_results.push_back(r);
    endfunction

    // One accepted item: up to MAX_RESULTS transitions, in fixed order.
    function void take_item(in_item_t it);
      int   n;
      logic sirq;
      n = 0;
      if (!it.display_on || it.stopped) return;
      acc = acc + it.cycles;
      if (acc > 65535) acc = 65535;
      if (line < VISIBLE_LINES) begin
        if (n < MAX_RESULTS && phase == PH_SCAN && acc >= thr_scan) begin
          phase = PH_TRANSFER;
          acc  -= thr_scan;
          mode  = MODE_TRANSFER;
          queue_result(EV_TRANSFER, 1'b0, 1'b0, 1'b0);
          n++;
        end
        if (n < MAX_RESULTS && phase == PH_TRANSFER && acc >= thr_xfer) begin
          phase = PH_HBLANK;
          acc  -= thr_xfer;
          mode  = MODE_HBLANK;
          queue_result(EV_HBLANK, it.ie_stat & it.stat_int_enables[0], 1'b0, 1'b0);
          n++;
        end
        if (n < MAX_RESULTS && phase == PH_HBLANK && acc >= thr_hblank) begin
          line  = (line + 1) & 'hff;
          phase = PH_SCAN;
          acc  -= thr_hblank;
          if (line == VISIBLE_LINES) begin
            mode = MODE_VBLANK;
            queue_result(EV_NEW_LINE, it.ie_stat & it.stat_int_enables[1], it.ie_vblank,
                         1'b1);
          end else begin
            mode = MODE_SCAN;
            queue_result(EV_NEW_LINE, it.ie_stat & it.stat_int_enables[2], 1'b0, 1'b0);
          end
          n++;
        end
      end
      if (n < MAX_RESULTS && line >= VISIBLE_LINES && line < LAST_LINE &&
          acc >= thr_hblank) begin
        line     = (line + 1) & 'hff;
        pub_line = line;
        acc     -= thr_hblank;
        sirq     = 1'b0;
        if (it.compare_line == pub_line[7:0]) begin
          cf   = 1'b1;
          sirq = it.ie_stat & it.stat_int_enables[3];
        end else begin
          cf = 1'b0;
        end
        queue_result(EV_VBLANK_STEP, sirq, 1'b0, 1'b0);
        n++;
      end
      if (n < MAX_RESULTS && line == LAST_LINE && acc >= thr_wrap) begin
        line  = 0;
        phase = PH_SCAN;
        acc  -= thr_wrap;
        mode  = MODE_SCAN;
        queue_result(EV_WRAP, it.ie_stat & it.stat_int_enables[2], 1'b0, 1'b0);
        n++;
      end
      if (n > 0) due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    function bit match_result(out_item_t got, output string msg);
      out_item_t want;
      msg = "";
      if (due_results.size() == 0) begin
        msg = $sformatf(" no result due: event %0d line %0d", got.event_res, got.line);
        return 1'b0;
      end
      want = due_results.pop_front();
      if (got.event_res !== want.event_res)
        msg = {msg, $sformatf(" event %0d/%0d", got.event_res, want.event_res)};
      if (got.line !== want.line)
        msg = {msg, $sformatf(" line %0d/%0d", got.line, want.line)};
      if (got.mode !== want.mode)
        msg = {msg, $sformatf(" mode %0d/%0d", got.mode, want.mode)};
      if (got.coincidence !== want.coincidence)
        msg = {msg, $sformatf(" coincidence %b/%b", got.coincidence, want.coincidence)};
      if (got.stat_irq !== want.stat_irq)
        msg = {msg, $sformatf(" stat_irq %b/%b", got.stat_irq, want.stat_irq)};
      if (got.vblank_irq !== want.vblank_irq)
        msg = {msg, $sformatf(" vblank_irq %b/%b", got.vblank_irq, want.vblank_irq)};
      if (got.frame_done !== want.frame_done)
        msg = {msg, $sformatf(" frame_done %b/%b", got.frame_done, want.frame_done)};
      if (got.last !== want.last)
        msg = {msg, $sformatf(" last %b/%b", got.last, want.last)};
      if (msg != "") msg = {$sformatf(" (want event %0d line %0d) got/want:",
                                      want.event_res, want.line), msg};
      return msg == "";
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  lsms_in_if  item_ch();
  lsms_out_if result_ch();

  lcd_scanline_mode_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (item_ch),
    .results   (result_ch)
  );

  scanline_tracker sb = new();

  int fail_count     = 0;
  int idle_cycles    = 0;
  int item_no        = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(string msg);
    if (fail_count < 40) $display("MISMATCH:%s", msg);
    fail_count++;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold;
    hold = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold     = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    string msg;
    bit    moved;
    moved = 1'b0;
    if (!rst) begin
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        moved = 1'b1;
        if (!sb.match_result(result_ch.item, msg)) report(msg);
      end
      if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1) begin
        moved = 1'b1;
        sb.take_item(item_ch.item);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Pacing rotates every 25 counted items: none, sender idle, receiver stall, both.
  task automatic send_item(in_item_t it);
    case ((item_no / 25) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.item  <= it;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
  endtask

  // The extra edge lets the monitor record the last transfer before pending() is read.
  task automatic settle(int tail);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_config(int s, int t, int h, int w);
    int v[4];
    v = '{s, t, h, w};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= 10'(v[i]);
      sb.set_reg(cfg_index_t'(i), v[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t mk_item(int cyc, bit on, bit stp, logic [3:0] en, bit ies,
                                       bit iev, int lyc);
    in_item_t it;
    it.cycles           = 8'(cyc);
    it.display_on       = on;
    it.stopped          = stp;
    it.stat_int_enables = en;
    it.ie_stat          = ies;
    it.ie_vblank        = iev;
    it.compare_line     = 8'(lyc);
    return it;
  endfunction

  function automatic in_item_t rand_item(int lo, int hi);
    in_item_t it;
    it.cycles           = 8'($urandom_range(hi, lo));
    it.display_on       = ($urandom_range(99) < 93);
    it.stopped          = ($urandom_range(99) < 5);
    it.stat_int_enables = 4'($urandom_range(15));
    it.ie_stat          = ($urandom_range(99) < 75);
    it.ie_vblank        = ($urandom_range(99) < 75);
    it.compare_line     = ($urandom_range(99) < 60) ? 8'($urandom_range(LAST_LINE,
                                                                        VISIBLE_LINES))
                                                     : 8'($urandom);
    return it;
  endfunction

  task automatic run_random(int count, int lo, int hi);
    in_item_t it;
    int       done;
    done = 0;
    while (done < count) begin
      it = rand_item(lo, hi);
      if (it.display_on && !it.stopped) begin
        done++;
        item_no++;
      end
      send_item(it);
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SCAN;
    cfg_data        = '0;
    item_ch.valid   = 1'b0;
    item_ch.item    = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset thresholds: ignored items, field extremes, single steps
    send_item(mk_item(255, 0, 0, 4'hf, 1, 1, 0));
    send_item(mk_item(255, 1, 1, 4'hf, 1, 1, 0));
    send_item(mk_item(0,   1, 0, 4'h0, 0, 0, 0));
    send_item(mk_item(79,  1, 0, 4'hf, 1, 1, 255));
    send_item(mk_item(1,   1, 0, 4'hf, 1, 1, 0));
    send_item(mk_item(255, 1, 0, 4'hf, 1, 1, 144));
    send_item(mk_item(255, 1, 0, 4'h4, 1, 0, 153));
    send_item(mk_item(255, 1, 0, 4'h0, 0, 0, 0));
    send_item(mk_item(255, 1, 0, 4'hf, 0, 1, 0));
    send_item(mk_item(255, 1, 0, 4'hf, 1, 0, 255));
    send_item(mk_item(128, 1, 0, 4'h5, 1, 1, 170));
    send_item(mk_item(200, 1, 0, 4'ha, 1, 1, 85));
    settle(6);

    // zero thresholds: every step fires, result cap per item
    set_config(0, 0, 0, 0);
    send_item(mk_item(0,   1, 0, 4'hf, 1, 1, 1));
    send_item(mk_item(255, 1, 0, 4'hf, 1, 1, 2));
    send_item(mk_item(0,   0, 1, 4'hf, 1, 1, 0));
    send_item(mk_item(17,  1, 0, 4'hf, 0, 0, 3));
    send_item(mk_item(255, 1, 0, 4'hf, 1, 1, 8'haa));
    send_item(mk_item(0,   1, 0, 4'h0, 1, 1, 0));
    settle(6);

    // short lines, long output hold-off at the start
    set_config($urandom_range(45, 20), $urandom_range(45, 20), $urandom_range(45, 20),
               $urandom_range(1023, 1));
    hold_req = 1'b1;
    run_random(30, 0, 255);
    settle(6);

    // zero thresholds with full cycle counts: several frames, accumulator saturates
    set_config(0, 0, 0, 0);
    run_random(265, 255, 255);
    settle(6);

    // largest thresholds drain the saturated accumulator
    set_config(1023, 1023, 1023, 1023);
    run_random(25, 0, 255);
    settle(6);

    set_config(1, 1023, 1, 1023);
    run_random(15, 0, 255);
    settle(6);

    set_config($urandom_range(1023, 1), $urandom_range(1023, 1), $urandom_range(1023, 1),
               $urandom_range(1023, 1));
    run_random(15, 0, 255);
    settle(10);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lsms_pkg.sv
rtl/lsms_if.sv
rtl/lsms_seq.sv
rtl/lsms_out.sv
rtl/lcd_scanline_mode_sequencer_core.sv
tb/tb_lcd_scanline_mode_sequencer_core.sv
